// ----- rtl/core/imp_pkg.sv -----
// ----------------------------------------------------------------------------
// imp_pkg
// Shared widths, limits, status codes and the line command for the
// mean power estimator.
// ----------------------------------------------------------------------------
package imp_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int SQ_W       = 2 * SAMPLE_W + 1;   // I*I + Q*Q
    localparam int CNT_W      = 15;                 // byte_count register
    localparam int PAIRS_W    = CNT_W - 1;          // pair count, pairs seen
    localparam int SUM_W      = 31;                 // energy sum
    localparam int FRAC_W     = 8;
    localparam int POWER_W    = 25;
    localparam int DIVIDEND_W = SUM_W + FRAC_W;
    localparam int STEP_W     = $clog2(DIVIDEND_W);

    localparam logic [CNT_W-1:0] BYTE_COUNT_RESET = 15'd16384;
    localparam logic [16:0]      MAX_PAIRS        = 17'd8192;

    localparam int LQ_DEPTH = 2;
    localparam int LQ_PTR_W = (LQ_DEPTH > 1) ? $clog2(LQ_DEPTH) : 1;
    localparam int LQ_CNT_W = $clog2(LQ_DEPTH + 1);

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_RANGE_ERR = 1'b1;

    typedef struct packed {
        logic               err;
        logic [SUM_W-1:0]   total;
        logic [PAIRS_W-1:0] npairs;
    } t_line_cmd;

endpackage

// ----- rtl/core/imp_front.sv -----
// ----------------------------------------------------------------------------
// imp_front
// Holds byte_count, accumulates I*I+Q*Q per pair and issues a line command
// when a line completes or the pair count is out of range.
// ----------------------------------------------------------------------------
module imp_front #(
    parameter logic [16:0] MAX_PAIRS = imp_pkg::MAX_PAIRS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [imp_pkg::CNT_W-1:0]         i_cfg_byte_count,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [imp_pkg::SAMPLE_W-1:0]      i_i_sample,
    input  logic [imp_pkg::SAMPLE_W-1:0]      i_q_sample,
    input  logic                              i_lq_full,
    output logic                              o_push,
    output imp_pkg::t_line_cmd                o_cmd
);

    logic [imp_pkg::CNT_W-1:0]      r_byte_count;
    logic [imp_pkg::SUM_W-1:0]      r_energy_sum;
    logic [imp_pkg::SUM_W-1:0]      n_energy_sum;
    logic [imp_pkg::PAIRS_W-1:0]    r_pairs_seen;
    logic [imp_pkg::PAIRS_W-1:0]    n_pairs_seen;

    logic [imp_pkg::PAIRS_W-1:0]    w_npairs;
    logic                           w_bad;
    logic [2*imp_pkg::SAMPLE_W-1:0] w_i_sq;
    logic [2*imp_pkg::SAMPLE_W-1:0] w_q_sq;
    logic [imp_pkg::SQ_W-1:0]       w_energy;
    logic [imp_pkg::SUM_W-1:0]      w_total;
    logic [imp_pkg::PAIRS_W:0]      w_seen;
    logic                           w_line_end;
    logic                           w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_lq_full;
    assign w_accept    = i_in_valid && !i_lq_full;

    assign w_npairs = r_byte_count[imp_pkg::CNT_W-1:1];
    assign w_bad    = (w_npairs == '0) ||
                      ({3'b000, w_npairs} > MAX_PAIRS);

    assign w_i_sq   = i_i_sample * i_i_sample;
    assign w_q_sq   = i_q_sample * i_q_sample;
    assign w_energy = {1'b0, w_i_sq} + {1'b0, w_q_sq};
    // the sum never exceeds 16383 full-scale pairs, so SUM_W bits hold it
    assign w_total  = r_energy_sum + imp_pkg::SUM_W'(w_energy);
    assign w_seen   = {1'b0, r_pairs_seen} + 1'b1;
    assign w_line_end = (w_seen >= {1'b0, w_npairs});

    assign o_push       = w_accept && (w_bad || w_line_end);
    assign o_cmd.err    = w_bad;
    assign o_cmd.total  = w_total;
    assign o_cmd.npairs = w_npairs;

    always_comb begin
        n_energy_sum = r_energy_sum;
        n_pairs_seen = r_pairs_seen;
        if (w_accept) begin
            if (w_bad || w_line_end) begin
                n_energy_sum = '0;
                n_pairs_seen = '0;
            end else begin
                n_energy_sum = w_total;
                n_pairs_seen = w_seen[imp_pkg::PAIRS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= imp_pkg::BYTE_COUNT_RESET;
            r_energy_sum <= '0;
            r_pairs_seen <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_byte_count <= i_cfg_byte_count;
            end
            r_energy_sum <= n_energy_sum;
            r_pairs_seen <= n_pairs_seen;
        end
    end

endmodule

// ----- rtl/core/imp_queue.sv -----
// ----------------------------------------------------------------------------
// imp_queue
// Short FIFO of line commands between the accumulator and the divider.
// ----------------------------------------------------------------------------
module imp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  imp_pkg::t_line_cmd  i_cmd,
    input  logic                i_pop,
    output imp_pkg::t_line_cmd  o_cmd,
    output logic                o_full,
    output logic                o_empty
);

    imp_pkg::t_line_cmd               r_mem [imp_pkg::LQ_DEPTH];
    logic [imp_pkg::LQ_PTR_W-1:0]     r_wr_ptr;
    logic [imp_pkg::LQ_PTR_W-1:0]     r_rd_ptr;
    logic [imp_pkg::LQ_CNT_W-1:0]     r_count;

    function automatic logic [imp_pkg::LQ_PTR_W-1:0] ptr_inc(
        input logic [imp_pkg::LQ_PTR_W-1:0] ptr
    );
        if (ptr == imp_pkg::LQ_PTR_W'(imp_pkg::LQ_DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    assign o_full  = (r_count == imp_pkg::LQ_CNT_W'(imp_pkg::LQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/imp_back.sv -----
// ----------------------------------------------------------------------------
// imp_back
// Takes line commands, divides sum*256 by the pair count one quotient bit
// per cycle, saturates and presents the result in an output register.
// ----------------------------------------------------------------------------
module imp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  imp_pkg::t_line_cmd                i_cmd,
    input  logic                              i_lq_empty,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [imp_pkg::POWER_W-1:0]       o_power_q8,
    output logic                              o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    t_state                            r_state;
    logic [imp_pkg::DIVIDEND_W-1:0]    r_quo;      // dividend in, quotient out
    logic [imp_pkg::PAIRS_W-1:0]       r_rem;
    logic [imp_pkg::PAIRS_W-1:0]       r_div;
    logic [imp_pkg::STEP_W-1:0]        r_step;
    logic                              r_err;
    logic                              r_out_valid;
    logic [imp_pkg::POWER_W-1:0]       r_power;
    logic                              r_status;

    logic [imp_pkg::PAIRS_W:0]         w_rem_sh;
    logic                              w_ge;
    logic [imp_pkg::PAIRS_W:0]         w_rem_sub;
    logic                              w_slot_free;
    logic                              w_sat;

    assign o_pop       = (r_state == S_IDLE) && !i_lq_empty;
    assign o_out_valid = r_out_valid;
    assign o_power_q8  = r_power;
    assign o_status    = r_status;

    assign w_rem_sh    = {r_rem, r_quo[imp_pkg::DIVIDEND_W-1]};
    assign w_ge        = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_sub   = w_rem_sh - {1'b0, r_div};
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_sat       = (r_quo[imp_pkg::DIVIDEND_W-1:imp_pkg::POWER_W] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_err       <= 1'b0;
        end else begin
            // drop the result once taken, unless the hold state replaces it
            if (r_out_valid && i_out_ready && (r_state != S_HOLD)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_lq_empty) begin
                        r_err <= i_cmd.err;
                        r_quo <= {i_cmd.total, imp_pkg::FRAC_W'(0)};
                        r_rem <= '0;
                        r_div <= i_cmd.npairs;
                        r_step <= imp_pkg::STEP_W'(imp_pkg::DIVIDEND_W - 1);
                        r_state <= i_cmd.err ? S_HOLD : S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo <= {r_quo[imp_pkg::DIVIDEND_W-2:0], w_ge};
                    r_rem <= w_ge ? w_rem_sub[imp_pkg::PAIRS_W-1:0]
                                  : w_rem_sh[imp_pkg::PAIRS_W-1:0];
                    if (r_step == '0) begin
                        r_state <= S_HOLD;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_HOLD: begin
                    // hold until the output register is free
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        if (r_err) begin
                            r_power  <= '0;
                            r_status <= imp_pkg::STATUS_RANGE_ERR;
                        end else begin
                            r_power  <= w_sat ? '1
                                              : r_quo[imp_pkg::POWER_W-1:0];
                            r_status <= imp_pkg::STATUS_OK;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/iq_mean_power_estimator.sv -----
// ----------------------------------------------------------------------------
// iq_mean_power_estimator
// Mean I/Q power over one range line, unsigned Q8 result with status.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  config    i_cfg_valid / o_cfg_ready   i_cfg_byte_count
//  input     i_in_valid  / o_in_ready    i_i_sample, i_q_sample
//  output    o_out_valid / i_out_ready   o_power_q8, o_status
//
//  The accumulator takes one pair per cycle; ready drops only while the
//  two-entry line command queue is full.
//  Each line end has the divider load the command, produce 39 quotient
//  bits, one per cycle, and then write the output; out-of-range requests
//  skip the division.
//  Reset is synchronous, active low; byte_count returns to 16384.
//  A stalled output holds the divider, which then fills the queue and
//  stalls the input.
// ----------------------------------------------------------------------------
module iq_mean_power_estimator #(
    parameter logic [16:0] MAX_PAIRS = imp_pkg::MAX_PAIRS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [imp_pkg::CNT_W-1:0]         i_cfg_byte_count,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [imp_pkg::SAMPLE_W-1:0]      i_i_sample,
    input  logic [imp_pkg::SAMPLE_W-1:0]      i_q_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [imp_pkg::POWER_W-1:0]       o_power_q8,
    output logic                              o_status
);

    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    imp_pkg::t_line_cmd w_push_cmd;
    imp_pkg::t_line_cmd w_head_cmd;

    imp_front #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_byte_count (i_cfg_byte_count),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_i_sample       (i_i_sample),
        .i_q_sample       (i_q_sample),
        .i_lq_full        (w_full),
        .o_push           (w_push),
        .o_cmd            (w_push_cmd)
    );

    imp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    imp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_head_cmd),
        .i_lq_empty  (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_power_q8  (o_power_q8),
        .o_status    (o_status)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("line command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("line command popped from an empty queue");

    a_err_power_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == imp_pkg::STATUS_RANGE_ERR)) |-> (o_power_q8 == '0))
        else $error("range error result carries nonzero power");
`endif

endmodule
